### rtl/rar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int RES_WIDTH = 33;

    // operation codes
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_CHECK,
        ST_REM,
        ST_REM_WAIT,
        ST_STEP,
        ST_QN,
        ST_QN_WAIT,
        ST_QD,
        ST_QD_WAIT,
        ST_OUT
    } state_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage : rar_pkg
`default_nettype wire

### rtl/rar_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rar_divider
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero; remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module rar_divider #(
    parameter int WIDTH = 34
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rar_pkg::div_ctrl_t      ctrl,
    input  wire logic signed [WIDTH-1:0] dividend,
    input  wire logic signed [WIDTH-1:0] divisor,
    output rar_pkg::div_stat_t           stat,
    output logic signed [WIDTH-1:0]      quotient,
    output logic signed [WIDTH-1:0]      remainder
);
    import rar_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   shifted;

    // one shift-subtract step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (ctrl.start)
        begin
            quo_next  = dividend[WIDTH-1] ? WIDTH'(-dividend) : dividend;
            dsr_next  = divisor[WIDTH-1] ? WIDTH'(-divisor) : divisor;
            rem_next  = '0;
            qneg_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            rneg_next = dividend[WIDTH-1];
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign stat.done = done_reg;
    assign quotient  = qneg_reg ? WIDTH'(-quo_reg) : quo_reg;
    assign remainder = rneg_reg ? WIDTH'(-rem_reg) : rem_reg;

endmodule : rar_divider
`default_nettype wire

### rtl/rational_arithmetic_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// Combines two fractions and reduces the result by a Euclidean gcd.
// ----------------------------------------------------------------------------
//  channel | signals                                          | dir
//  in      | in_valid/in_ready, mode, a_*, b_*                | in
//  out     | out_valid/out_ready, result_*, is_positive, error| out
//
//  Sequence: accept, multiply states MUL0 and MUL1 and a check, then for
//  each Euclid step a divider start, the serial division and the step;
//  then the two final quotients and a load of the output register.
//  A zero denominator skips the divider. Reset clears the sequencer and
//  output valid. in_ready is high only in idle; the result holds in the
//  output register until taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_denominator,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_denominator,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [rar_pkg::RES_WIDTH-1:0] result_numerator,
    output logic signed [rar_pkg::RES_WIDTH-1:0] result_denominator,
    output logic                               is_positive,
    output logic                               error
);
    import rar_pkg::*;

    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int VW = PW + 2;

    state_t state_reg, state_next;
    logic [1:0] mode_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [OPERAND_WIDTH-1:0] ma, mb;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] p0_reg;
    logic signed [VW-1:0] n_reg, n_next, d_reg, d_next;
    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [VW-1:0] g_reg;
    logic signed [VW-1:0] qn_reg;
    logic pos_reg;
    logic signed [VW-1:0] div_a, div_b, quo, rem;
    div_ctrl_t dctrl;
    div_stat_t dstat;
    logic out_valid_reg;
    logic signed [RES_WIDTH-1:0] rn_reg, rd_reg;
    logic pos_out_reg, err_reg;

    rar_divider #(.WIDTH(VW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctrl(dctrl),
        .dividend(div_a), .divisor(div_b),
        .stat(dstat), .quotient(quo), .remainder(rem)
    );

    // shared multiplier operand select
    always_comb
    begin
        ma = an_reg;
        mb = bd_reg;
        unique case (state_reg)
            ST_MUL0:
            begin
                ma = (mode_reg == MODE_MUL) ? an_reg : ad_reg;
                mb = (mode_reg == MODE_MUL) ? bn_reg :
                     (mode_reg == MODE_SUB) ? bn_reg :
                     (mode_reg == MODE_DIV) ? bn_reg : bn_reg;
            end
            ST_MUL1:
            begin
                ma = (mode_reg == MODE_MUL) ? ad_reg : an_reg;
                mb = bd_reg;
            end
            default:
            begin
                ma = an_reg;
                mb = bd_reg;
            end
        endcase
    end
    assign prod = PW'(ma * mb);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL0;
            ST_MUL0:     state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_CHECK;
            ST_CHECK:    state_next = (d_reg == '0) ? ST_OUT : ST_REM;
            ST_REM:      state_next = ST_REM_WAIT;
            ST_REM_WAIT: if (dstat.done) state_next = ST_STEP;
            ST_STEP:     state_next = (rem == '0) ? ST_QN : ST_REM;
            ST_QN:       state_next = ST_QN_WAIT;
            ST_QN_WAIT:  if (dstat.done) state_next = ST_QD;
            ST_QD:       state_next = ST_QD_WAIT;
            ST_QD_WAIT:  if (dstat.done) state_next = ST_OUT;
            ST_OUT:      if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        dctrl.start = 1'b0;
        div_a = x_reg;
        div_b = y_reg;
        unique case (state_reg)
            ST_REM: dctrl.start = 1'b1;
            ST_QN:
            begin
                dctrl.start = 1'b1;
                div_a = n_reg;
                div_b = g_reg;
            end
            ST_QD:
            begin
                dctrl.start = 1'b1;
                div_a = d_reg;
                div_b = g_reg;
            end
            default: dctrl.start = 1'b0;
        endcase
    end

    // raw numerator and denominator
    always_comb
    begin
        n_next = n_reg;
        d_next = d_reg;
        if (state_reg == ST_MUL0)
        begin
            d_next = VW'(ad_reg * bd_reg);
            if (mode_reg == MODE_DIV)
                d_next = VW'(prod);
        end
        if (state_reg == ST_MUL1)
        begin
            unique case (mode_reg)
                MODE_ADD: n_next = VW'(p0_reg) + VW'(prod);
                MODE_SUB: n_next = VW'(prod) - VW'(p0_reg);
                MODE_MUL: n_next = VW'(p0_reg);
                default:  n_next = VW'(prod);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            mode_reg <= mode;
            an_reg   <= a_numerator;
            ad_reg   <= a_denominator;
            bn_reg   <= b_numerator;
            bd_reg   <= b_denominator;
        end
        if (state_reg == ST_MUL0)
            p0_reg <= prod;
        n_reg <= n_next;
        d_reg <= d_next;
        if (state_reg == ST_CHECK)
        begin
            x_reg   <= n_reg;
            y_reg   <= d_reg;
            pos_reg <= !((n_reg < 0 && d_reg > 0) || (n_reg > 0 && d_reg < 0));
            g_reg   <= d_reg;
        end
        if (state_reg == ST_STEP)
        begin
            x_reg <= y_reg;
            y_reg <= rem;
            if (rem == '0)
                g_reg <= y_reg;
        end
        if (state_reg == ST_QN_WAIT && dstat.done)
            qn_reg <= quo;
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            if (d_reg == '0)
            begin
                rn_reg      <= '0;
                rd_reg      <= '0;
                pos_out_reg <= 1'b0;
                err_reg     <= 1'b1;
            end
            else
            begin
                rn_reg      <= RES_WIDTH'(qn_reg);
                rd_reg      <= RES_WIDTH'(quo);
                pos_out_reg <= pos_reg;
                err_reg     <= 1'b0;
            end
        end
    end

    assign in_ready           = (state_reg == ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign result_numerator   = rn_reg;
    assign result_denominator = rd_reg;
    assign is_positive        = pos_out_reg;
    assign error              = err_reg;

endmodule : rational_arithmetic_reduce
`default_nettype wire

### bench/rar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_checker
// Watches both channels of the rational reduce block. It predicts each
// result from the accepted input beat and compares it with the output beat.
// ----------------------------------------------------------------------------
module rar_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [OPERAND_WIDTH-1:0]     a_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0]     a_denominator,
    input  wire logic signed [OPERAND_WIDTH-1:0]     b_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0]     b_denominator,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [rar_pkg::RES_WIDTH-1:0] result_numerator,
    input  wire logic signed [rar_pkg::RES_WIDTH-1:0] result_denominator,
    input  wire logic                                is_positive,
    input  wire logic                                error,
    output int                                       fail_count,
    output int                                       pending
);
    import rar_pkg::*;

    typedef struct packed {
        logic [RES_WIDTH-1:0] num;
        logic [RES_WIDTH-1:0] den;
        logic                 pos;
        logic                 err;
    } fraction_t;

    fraction_t reduced_q[$];

    // Combine the operands and reduce by the signed Euclid gcd
    function automatic fraction_t reduce_fraction(logic [1:0] op,
        longint an, longint ad, longint bn, longint bd);
        fraction_t f;
        longint n, d, r, x, y;
        case (mode_t'(op))
            MODE_ADD: begin n = ad * bn + bd * an; d = ad * bd; end
            MODE_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
            MODE_MUL: begin n = an * bn;           d = ad * bd; end
            default:  begin n = an * bd;           d = ad * bn; end
        endcase
        f = '0;
        if (d == 0)
        begin
            f.err = 1'b1;
            return f;
        end
        f.pos = !((n < 0 && d > 0) || (n > 0 && d < 0));
        x = n;
        y = d;
        r = x % y;
        while (r != 0)
        begin
            x = y;
            y = r;
            r = x % y;
        end
        f.num = RES_WIDTH'(n / y);
        f.den = RES_WIDTH'(d / y);
        return f;
    endfunction

    assign pending = reduced_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t exp_f;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            // input beat: queue the prediction
            if (in_valid && in_ready)
                reduced_q.push_back(reduce_fraction(mode, longint'(a_numerator),
                    longint'(a_denominator), longint'(b_numerator),
                    longint'(b_denominator)));
            // output beat: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (reduced_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errs++;
                end
                else
                begin
                    exp_f = reduced_q.pop_front();
                    if (result_numerator !== exp_f.num)
                    begin
                        $error("result_numerator: expected %0d, got %0d",
                            $signed(exp_f.num), result_numerator);
                        errs++;
                    end
                    if (result_denominator !== exp_f.den)
                    begin
                        $error("result_denominator: expected %0d, got %0d",
                            $signed(exp_f.den), result_denominator);
                        errs++;
                    end
                    if (is_positive !== exp_f.pos)
                    begin
                        $error("is_positive: expected %0b, got %0b",
                            exp_f.pos, is_positive);
                        errs++;
                    end
                    if (error !== exp_f.err)
                    begin
                        $error("error: expected %0b, got %0b", exp_f.err, error);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

### bench/tb_rational_arithmetic_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_reduce
// Drives directed and random fraction pairs through the reduce block with
// random gaps and output stalls; the checker judges every result beat.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_reduce;
    import rar_pkg::*;

    localparam int OW = 16;
    localparam int N_RANDOM = 350;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic signed [OW-1:0] a_numerator = '0;
    logic signed [OW-1:0] a_denominator = '0;
    logic signed [OW-1:0] b_numerator = '0;
    logic signed [OW-1:0] b_denominator = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [RES_WIDTH-1:0] result_numerator;
    logic signed [RES_WIDTH-1:0] result_denominator;
    logic is_positive;
    logic error;
    int fail_count;
    int pending;

    always #5 clk = ~clk;

    rational_arithmetic_reduce #(.OPERAND_WIDTH(OW)) dut (.*);

    rar_checker #(.OPERAND_WIDTH(OW)) checker_i (.*);

    // Send one beat after a random gap, hold until accepted
    task automatic send_fraction(logic [1:0] op, logic [OW-1:0] an,
        logic [OW-1:0] ad, logic [OW-1:0] bn, logic [OW-1:0] bd);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(posedge clk);
        in_valid      <= 1'b1;
        mode          <= op;
        a_numerator   <= an;
        a_denominator <= ad;
        b_numerator   <= bn;
        b_denominator <= bd;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
    endtask

    // Random operand: often small, sometimes extreme, zero or full range
    function automatic logic [OW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return OW'($urandom_range(0, 65535));
            3: return OW'($urandom_range(0, 65535));
            4: return '0;
            default: return OW'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Output side: random stall per beat, with stall-free stretches
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            repeat (stall) @(posedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            out_ready <= 1'b0;
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // extremes, every operation, zero denominators, zero numerators
        for (int op = 0; op < 4; op++)
        begin
            send_fraction(2'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_fraction(2'(op), 16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF);
            send_fraction(2'(op), 16'h0003, 16'h0000, 16'h0005, 16'h0007);
            send_fraction(2'(op), 16'h0000, 16'h0004, 16'h0000, 16'hFFFA);
            send_fraction(2'(op), 16'hFFFE, 16'h0006, 16'h0004, 16'hFFF7);
        end
        send_fraction(MODE_DIV, 16'h0001, 16'h0002, 16'h0000, 16'h0003);
        send_fraction(MODE_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_fraction(MODE_SUB, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        for (int i = 0; i < N_RANDOM; i++)
            send_fraction(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
        // let the last prediction reach the queue before draining
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
